// File: src/mdg_pkg.sv
// ----------------------------------------------------------------------------
// Middle-digit generator package
// Widths, codes and shared types for the middle-digit generator.
// ----------------------------------------------------------------------------
package mdg_pkg;

  // Width of a stored value, a seed, the multiplier and a result.
  localparam int VAL_W      = 14;
  localparam int MODE_W     = 2;
  // Number of decimal digits kept from the product.
  localparam int DIGITS     = 4;
  localparam int PROD_W     = 2 * VAL_W;
  // Decimal digits needed for a PROD_W-bit number: floor(PROD_W * log10(2)) + 1.
  localparam int BCD_DIGITS = (PROD_W * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int LEN_W      = $clog2(BCD_DIGITS + 2);
  localparam int CNT_W      = $clog2(PROD_W);

  localparam logic [MODE_W-1:0] MODE_SQUARE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRODUCT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONST   = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MULT = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CONV,
    ST_SEL
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

endpackage

// File: src/mdg_bcd_conv.sv
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 conversion of the product, one bit per cycle.
// ----------------------------------------------------------------------------
module mdg_bcd_conv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mdg_pkg::PROD_W-1:0] bin_i,
  output logic [mdg_pkg::BCD_W-1:0]  bcd_o,
  output mdg_pkg::conv_status_t      status_o
);
  import mdg_pkg::*;

  logic [PROD_W-1:0] shift_q, shift_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if (bcd_q[4*j +: 4] >= 4'd5) begin
        bcd_adj[4*j +: 4] = bcd_q[4*j +: 4] + 4'd3;
      end else begin
        bcd_adj[4*j +: 4] = bcd_q[4*j +: 4];
      end
    end
  end

  always_comb begin
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = bin_i;
      bcd_d   = '0;
      cnt_d   = CNT_W'(PROD_W - 1);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      {bcd_d, shift_d} = {bcd_adj[BCD_W-2:0], shift_q, 1'b0};
      cnt_d            = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  assign bcd_o           = bcd_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

// File: src/mdg_digit_select.sv
// ----------------------------------------------------------------------------
// Middle digit selector
// Pads the digit count to an even number and picks the middle digits.
// ----------------------------------------------------------------------------
module mdg_digit_select (
  input  logic [mdg_pkg::BCD_W-1:0]  bcd_i,
  input  logic [mdg_pkg::PROD_W-1:0] prod_i,
  output logic [mdg_pkg::VAL_W-1:0]  value_o
);
  import mdg_pkg::*;

  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    padded;
  logic [LEN_W-1:0]    drop;
  logic [BCD_W-1:0]    bcd_sh;
  logic [VAL_W-1:0]    acc;

  always_comb begin
    len = LEN_W'(1);
    for (int j = 0; j < BCD_DIGITS; j++) begin
      if (bcd_i[4*j +: 4] != 4'd0) begin
        len = LEN_W'(j + 1);
      end
    end
  end

  assign padded = len + {{(LEN_W-1){1'b0}}, len[0]};
  assign drop   = (padded - LEN_W'(DIGITS)) >> 1;
  assign bcd_sh = bcd_i >> {drop, 2'b00};

  // Decimal window back to binary, most significant digit first.
  always_comb begin
    acc = '0;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      acc = (acc << 3) + (acc << 1) + VAL_W'(bcd_sh[4*k +: 4]);
    end
  end

  // Short products are passed on as they are.
  assign value_o = (padded < LEN_W'(DIGITS)) ? prod_i[VAL_W-1:0] : acc;

endmodule

// File: src/middle_digit_generator.sv
// ----------------------------------------------------------------------------
// Middle-digit generator
// Four-digit middle square, middle product and constant multiplier scheme.
// ----------------------------------------------------------------------------
// The input channel carries a command with two seeds. A load beat stores the
// seeds and gives no result. A step beat forms a product from the stored
// values (square, older times newer, or multiplier times value), converts it
// to decimal and returns the middle four digits on the output channel as one
// beat; value / 10000 is the random fraction.
// A step passes from acceptance through the multiply state, which starts the
// converter on the 14x14 product, the bit-serial decimal conversion, the
// converter's done flag and digit selection to the output register. Input
// ready is low throughout and rises again once the sequencer is back in idle,
// so steps run one at a time. The result waits in the output register while
// the receiver stalls; input is taken again meanwhile, but a following step
// holds in the selection cycle until the output register is free.
// Mode and multiplier are written through the configuration port; the user
// must write them only while idle, which the block itself does not enforce.
// Reset clears both registers, both stored values and the output valid.
// ----------------------------------------------------------------------------
module middle_digit_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [mdg_pkg::VAL_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [mdg_pkg::VAL_W-1:0]  seed_first_i,
  input  logic [mdg_pkg::VAL_W-1:0]  seed_second_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mdg_pkg::VAL_W-1:0]  value_o
);
  import mdg_pkg::*;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [VAL_W-1:0]    mult_q;
  logic [VAL_W-1:0]    older_q, older_d;
  logic [VAL_W-1:0]    newer_q, newer_d;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W-1:0]    op_a, op_b;
  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_value_q;
  logic [BCD_W-1:0]    bcd;
  logic [VAL_W-1:0]    sel_value;
  conv_status_t        conv_st;
  logic                in_fire;
  logic                conv_start;
  logic                commit;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    op_a = older_q;
    op_b = older_q;
    case (mode_q)
      MODE_PRODUCT: op_b = newer_q;
      MODE_CONST:   op_a = mult_q;
      default:      op_b = older_q;
    endcase
  end

  assign prod = PROD_W'(op_a) * PROD_W'(op_b);

  mdg_bcd_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .bin_i    (prod),
    .bcd_o    (bcd),
    .status_o (conv_st)
  );

  mdg_digit_select u_select (
    .bcd_i   (bcd),
    .prod_i  (prod_q),
    .value_o (sel_value)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && command_i == CMD_STEP) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_CONV;
      ST_CONV: begin
        if (conv_st.done) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    conv_start = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MUL:  conv_start = 1'b1;
      ST_CONV: ;
      ST_SEL:  commit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    older_d = older_q;
    newer_d = newer_q;
    if (in_fire && command_i == CMD_LOAD) begin
      older_d = seed_first_i;
      newer_d = seed_second_i;
    end else if (commit) begin
      if (mode_q == MODE_PRODUCT) begin
        older_d = newer_q;
        newer_d = sel_value;
      end else begin
        older_d = sel_value;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SQUARE;
      mult_q      <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      older_q     <= older_d;
      newer_q     <= newer_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) begin
          mode_q <= cfg_wdata_i[MODE_W-1:0];
        end else if (cfg_idx_i == REG_MULT) begin
          mult_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_start) prod_q <= prod;
    if (commit) out_value_q <= sel_value;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

`ifndef ASSERT_OFF
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_st.done |-> state_q == ST_CONV)
    else $error("converter finished outside the conversion state");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !conv_st.busy)
    else $error("converter busy while the sequencer is idle");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> value_o <= VAL_W'(9999))
    else $error("result exceeds four decimal digits");

  a_result_from_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_SEL))
    else $error("result appeared without a selection cycle");
`endif

endmodule

// File: sim/tb_middle_digit_generator.sv
// ----------------------------------------------------------------------------
// Middle-digit generator testbench
// Drives load and step beats into the generator under changing mode and
// multiplier settings and checks every output beat against a predictor of
// the square, product and constant-multiplier schemes. A short table of
// directed beats comes first, then random phases with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_middle_digit_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mdg_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RAND_ITEMS   = 500;
  localparam int SETTLE       = 40;
  localparam int HOLD_AT      = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_GAP      = 16;
  localparam int MAX_SEED     = 9999;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic             set_cfg;
    logic [VAL_W-1:0] mode_w;
    logic [VAL_W-1:0] mult;
    logic             cmd;
    logic [VAL_W-1:0] seed_a;
    logic [VAL_W-1:0] seed_b;
    logic             known;
    logic [VAL_W-1:0] value;
  } dir_row_t;

  typedef struct packed {
    logic             known;
    logic [VAL_W-1:0] value;
  } typed_val_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // Zero state after reset squares to zero.
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_LOAD, 14'd9999, 14'd9999, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd9800},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd400},
    // Short products come back unchanged.
    '{1'b0, 14'd0, 14'd0, CMD_LOAD, 14'd9, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd81},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd6561},
    // Seeds above the decimal range.
    '{1'b0, 14'd0, 14'd0, CMD_LOAD, 14'h3FFF, 14'h3FFF, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b1, 14'(MODE_PRODUCT), 14'd0, CMD_LOAD, 14'd1234, 14'd5678, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_LOAD, 14'd0, 14'd9999, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd0},
    '{1'b1, 14'(MODE_CONST), 14'd9999, CMD_LOAD, 14'd9999, 14'd0, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd9800},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    // Multiplier changes between steps without a fresh load.
    '{1'b1, 14'(MODE_CONST), 14'h3FFF, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b1, 14'(MODE_CONST), 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b1, 14'd0},
    // The spare mode code, and mode writes with the upper bits set.
    '{1'b1, 14'h3FFF, 14'd5, CMD_LOAD, 14'd50, 14'h3FFF, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0},
    '{1'b1, 14'h3FFD, 14'h2AAA, CMD_LOAD, 14'h3FFF, 14'h3FFF, 1'b0, 14'd0},
    '{1'b0, 14'd0, 14'd0, CMD_STEP, 14'd0, 14'd0, 1'b0, 14'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [VAL_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  logic [VAL_W-1:0] seed_first_i;
  logic [VAL_W-1:0] seed_second_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [VAL_W-1:0] value_o;

  // Predictor copy of the registers and the stored values.
  logic [MODE_W-1:0] pred_mode  = '0;
  logic [VAL_W-1:0]  pred_mult  = '0;
  logic [VAL_W-1:0]  pred_older = '0;
  logic [VAL_W-1:0]  pred_newer = '0;

  logic [VAL_W-1:0] value_q [$];
  typed_val_t       typed_q [$];

  int errors     = 0;
  int n_loads    = 0;
  int n_steps    = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int idle_count = 0;

  middle_digit_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .seed_first_i (seed_first_i),
    .seed_second_i(seed_second_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Pads the decimal length of the product to an even count and keeps the
  // middle digits; products too short for that come back as they are.
  function automatic logic [VAL_W-1:0] middle_of(longint unsigned prod);
    longint unsigned rest;
    longint unsigned div;
    longint unsigned keep;
    int len;
    len = 0;
    rest = prod;
    do begin
      len++;
      rest = rest / 10;
    end while (rest != 0);
    if (len % 2 != 0) len++;
    if (len < DIGITS) return prod[VAL_W-1:0];
    div = 1;
    repeat ((len - DIGITS) / 2) div = div * 10;
    keep = 1;
    repeat (DIGITS) keep = keep * 10;
    rest = (prod / div) % keep;
    return rest[VAL_W-1:0];
  endfunction

  // Idle cycles before the next beat, with occasional runs of back-to-back beats.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [VAL_W-1:0] draw_seed();
    case ($urandom_range(0, 9))
      0, 1:    return VAL_W'($urandom_range(0, 99));
      2, 3:    return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, MAX_SEED));
    endcase
  endfunction

  // Predictor, checker and stall watchdog, all sampled at the rising edge.
  always @(posedge clk_i) begin
    logic [VAL_W-1:0] nxt;
    logic [VAL_W-1:0] want;
    typed_val_t       typed;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) pred_mode = cfg_wdata_i[MODE_W-1:0];
        else pred_mult = cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        if (value_q.size() == 0) begin
          $error("unexpected result beat: value %0d", value_o);
          errors++;
        end else begin
          want = value_q.pop_front();
          n_checked++;
          if (value_o !== want) begin
            $error("value mismatch: expected %0d, actual %0d", want, value_o);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (command_i == CMD_LOAD) begin
          pred_older = seed_first_i;
          pred_newer = seed_second_i;
          n_loads++;
        end else begin
          case (pred_mode)
            MODE_PRODUCT: begin
              nxt = middle_of(64'(pred_older) * 64'(pred_newer));
              pred_older = pred_newer;
              pred_newer = nxt;
            end
            MODE_CONST: begin
              nxt = middle_of(64'(pred_mult) * 64'(pred_older));
              pred_older = nxt;
            end
            default: begin
              nxt = middle_of(64'(pred_older) * 64'(pred_older));
              pred_older = nxt;
            end
          endcase
          typed = typed_q.pop_front();
          value_q.push_back(typed.known ? typed.value : nxt);
          n_steps++;
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= STALL_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Output side: random back-pressure, plus one long hold-off so that the
  // generator fills up and stops taking input.
  initial begin
    int burst;
    int gap;
    int beats;
    burst = 0;
    beats = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      beats++;
      gap = (beats == HOLD_AT) ? HOLD_CYCLES : draw_gap(burst);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  int in_burst = 0;

  task automatic offer(input logic cmd, input logic [VAL_W-1:0] seed_a,
                       input logic [VAL_W-1:0] seed_b, input logic known,
                       input logic [VAL_W-1:0] value);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (cmd == CMD_STEP) typed_q.push_back('{known, value});
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    seed_first_i  <= seed_a;
    seed_second_i <= seed_b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Called at the edge of the last accepted beat: stop offering, wait for
  // every result, then give a trailing load time to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [VAL_W-1:0] mode_w, input logic [VAL_W-1:0] mult);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MODE;
    cfg_wdata_i <= mode_w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MULT;
    cfg_wdata_i <= mult;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    dir_row_t         row;
    logic [VAL_W-1:0] mode_w;
    logic [VAL_W-1:0] mult;
    logic             cmd;
    int               sent;
    int               len;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MODE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CMD_LOAD;
    seed_first_i  = '0;
    seed_second_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TAB[i];
      if (row.set_cfg) begin
        settle();
        write_regs(row.mode_w, row.mult);
      end
      offer(row.cmd, row.seed_a, row.seed_b, row.known, row.value);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      case ($urandom_range(0, 6))
        0, 1:    mode_w = VAL_W'(MODE_SQUARE);
        2, 3:    mode_w = VAL_W'(MODE_PRODUCT);
        4, 5:    mode_w = VAL_W'(MODE_CONST);
        default: mode_w = VAL_W'(MODE_SPARE);
      endcase
      if ($urandom_range(0, 3) == 0) mode_w[VAL_W-1:MODE_W] = (VAL_W - MODE_W)'($urandom);
      case ($urandom_range(0, 5))
        0:       mult = '0;
        1:       mult = VAL_W'(MAX_SEED);
        2:       mult = '1;
        3:       mult = VAL_W'(1);
        4:       mult = VAL_W'($urandom_range(0, MAX_SEED));
        default: mult = VAL_W'($urandom);
      endcase
      write_regs(mode_w, mult);
      // Most phases open with a load; the rest run on from the old state.
      len = $urandom_range(10, 50);
      for (int k = 0; k < len; k++) begin
        if (k == 0) cmd = ($urandom_range(0, 4) != 0) ? CMD_LOAD : CMD_STEP;
        else cmd = ($urandom_range(0, 7) == 0) ? CMD_LOAD : CMD_STEP;
        offer(cmd, draw_seed(), draw_seed(), 1'b0, '0);
        sent++;
      end
    end
    settle();

    $display("Run covered %0d load and %0d step beats under %0d register settings;",
             n_loads, n_steps, n_settings);
    $display("%0d result beats were checked against the predictor.", n_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
